### sv/ips_pkg.sv
// Shared types, constants and codes of the injector pulse scheduler.
`default_nettype none
package ips_pkg;

  localparam int CHANNELS_DEF   = 4;
  localparam int COUNT_BITS_DEF = 25;

  localparam int OP_W    = 2;
  localparam int CH_W    = 4;
  localparam int TIME_W  = 25;
  localparam int REQ_W   = 24;
  localparam int WIDTH_W = 20;
  localparam int ERR_W   = 2;
  localparam int PINS_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_SCHED  = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP   = 2'd2;
  localparam logic [OP_W-1:0] OP_STATUS = 2'd3;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_REJECTED = 2'd1;
  localparam logic [ERR_W-1:0] ERR_SAFETY   = 2'd2;
  localparam logic [ERR_W-1:0] ERR_PASSED   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_W  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_W  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAFETY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd4;

  localparam logic [WIDTH_W-1:0] MIN_W_RST  = 20'd500;
  localparam logic [WIDTH_W-1:0] MAX_W_RST  = 20'd18000;
  localparam logic [WIDTH_W-1:0] SAFETY_RST = 20'd18000;
  localparam logic [TIME_W-1:0]  PERIOD_RST = 25'd30000000;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [CH_W-1:0]   channel;
    logic [TIME_W-1:0] start_time;
    logic [REQ_W-1:0]  pulse_width;
  } ips_in_t;

  typedef struct packed {
    logic                ok;
    logic [ERR_W-1:0]    error_code;
    logic [PINS_W-1:0]   pin_levels;
    logic                channel_active;
    logic [WIDTH_W-1:0]  channel_width;
    logic [TIME_W-1:0]   channel_last_count;
    logic [TIME_W-1:0]   current_count;
  } ips_out_t;

  typedef struct packed {
    logic                enabled;
    logic [WIDTH_W-1:0]  min_w;
    logic [WIDTH_W-1:0]  max_w;
    logic [WIDTH_W-1:0]  safety;
    logic [TIME_W-1:0]   period;
  } ips_cfg_t;

  typedef struct packed {
    logic tick;
    logic load;
    logic halt;
  } ips_cmd_t;

endpackage
`default_nettype wire

### sv/ips_cfg_regs.sv
// Configuration register file of the injector pulse scheduler.
`default_nettype none
module ips_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [ips_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [ips_pkg::CFG_DATA_W-1:0] wr_data,
  output ips_pkg::ips_cfg_t                   cfg
);
  import ips_pkg::*;

  ips_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled <= 1'b0;
      cfg_r.min_w   <= MIN_W_RST;
      cfg_r.max_w   <= MAX_W_RST;
      cfg_r.safety  <= SAFETY_RST;
      cfg_r.period  <= PERIOD_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_ENABLE: cfg_r.enabled <= wr_data[0];
        CFG_MIN_W:  cfg_r.min_w   <= wr_data[WIDTH_W-1:0];
        CFG_MAX_W:  cfg_r.max_w   <= wr_data[WIDTH_W-1:0];
        CFG_SAFETY: cfg_r.safety  <= wr_data[WIDTH_W-1:0];
        CFG_PERIOD: cfg_r.period  <= wr_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### sv/ips_timebase.sv
// Time base counter that steps on each tick and wraps to zero at the set period.
`default_nettype none
module ips_timebase #(
  parameter int CW = ips_pkg::COUNT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       tick,
  input  wire logic [ips_pkg::TIME_W-1:0] period,
  output logic [CW-1:0]                   count,
  output logic [CW-1:0]                   count_nxt,
  output logic                            wrap
);
  import ips_pkg::*;

  localparam int CMPW = (CW + 1 > TIME_W) ? CW + 1 : TIME_W;

  logic [CW-1:0] count_r;
  logic [CW:0]   inc;

  assign inc  = {1'b0, count_r} + {{CW{1'b0}}, 1'b1};
  assign wrap = CMPW'(inc) >= CMPW'(period);

  always_comb begin
    count_nxt = count_r;
    if (tick) begin
      count_nxt = wrap ? '0 : inc[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule
`default_nettype wire

### sv/ips_channel.sv
// One injector channel: compares, force, pin level and bookkeeping.
`default_nettype none
module ips_channel #(
  parameter int CW = ips_pkg::COUNT_BITS_DEF,
  parameter int EW = CW + 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  ips_pkg::ips_cmd_t                cmd,
  input  wire logic                        wrap,
  input  wire logic [CW-1:0]               count,
  input  wire logic [CW-1:0]               count_nxt,
  input  wire logic [CW-1:0]               load_start,
  input  wire logic [EW-1:0]               load_end,
  input  wire logic [ips_pkg::WIDTH_W-1:0] load_width,
  output logic                             pin_nxt,
  output logic                             active_nxt,
  output logic [ips_pkg::WIDTH_W-1:0]      width_nxt,
  output logic [CW-1:0]                    sched_nxt
);
  import ips_pkg::*;

  logic [CW-1:0]      start_r, start_nxt;
  logic [EW-1:0]      end_r, end_nxt;
  logic               forced_r, forced_nxt;
  logic               pin_r;
  logic               active_r;
  logic [WIDTH_W-1:0] width_r;
  logic [CW-1:0]      sched_r;

  always_comb begin
    start_nxt  = start_r;
    end_nxt    = end_r;
    forced_nxt = forced_r;
    pin_nxt    = pin_r;
    active_nxt = active_r;
    width_nxt  = width_r;
    sched_nxt  = sched_r;
    if (cmd.tick) begin
      if (wrap) begin
        pin_nxt = 1'b0;
      end
      if (forced_r) begin
        pin_nxt = 1'b0;
      end else begin
        if (count_nxt == start_r) begin
          pin_nxt = 1'b1;
        end
        if (EW'(count_nxt) == end_r) begin
          pin_nxt = 1'b0;
        end
      end
    end
    if (cmd.halt) begin
      forced_nxt = 1'b1;
      pin_nxt    = 1'b0;
      width_nxt  = '0;
      active_nxt = 1'b0;
    end
    if (cmd.load) begin
      start_nxt  = load_start;
      end_nxt    = load_end;
      forced_nxt = 1'b0;
      width_nxt  = load_width;
      active_nxt = 1'b1;
      sched_nxt  = count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      end_r    <= '0;
      forced_r <= 1'b1;
      pin_r    <= 1'b0;
      active_r <= 1'b0;
      width_r  <= '0;
      sched_r  <= '0;
    end else begin
      start_r  <= start_nxt;
      end_r    <= end_nxt;
      forced_r <= forced_nxt;
      pin_r    <= pin_nxt;
      active_r <= active_nxt;
      width_r  <= width_nxt;
      sched_r  <= sched_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/injector_pulse_scheduler_top.sv
// Top level of the injector pulse scheduler: handshake, decode and result word.
`default_nettype none
// Four-channel injector pulse generator on a shared time base that counts one
// step per tick word and wraps to zero at the programmed period. Every input
// word yields exactly one result word. The block takes one word per clock
// cycle while its input register is empty or the result register is free or
// being emptied; a word passes an input register and is resolved against the
// channel and time base registers into the result register once that
// register is free. The configuration port is always ready and must only be
// written while no word is in flight. Pins go high when the count meets a
// channel's start compare and low at its end compare, at wrap, or when the
// channel is stopped or cut by a safety fault.
module injector_pulse_scheduler_top #(
  parameter int CHANNELS   = ips_pkg::CHANNELS_DEF,
  parameter int COUNT_BITS = ips_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  ips_pkg::ips_in_t                    in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output ips_pkg::ips_out_t                   out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ips_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ips_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ips_pkg::*;

  localparam int CW   = COUNT_BITS;
  localparam int EW   = ((CW > WIDTH_W) ? CW : WIDTH_W) + 1;
  localparam int XW   = (CW > TIME_W) ? CW : TIME_W;
  localparam int CIW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW   = (CHANNELS > PINS_W) ? CHANNELS : PINS_W;

  ips_cfg_t cfg;

  logic     s1_valid_r;
  ips_in_t  s1_data_r;
  logic     out_valid_r;
  ips_out_t out_data_r;
  logic     out_free;
  logic     fire;

  logic          is_tick, ch_ok, rej, do_sched, over, passed, do_load, do_halt;
  logic [CIW-1:0] chan_idx;
  logic [CW-1:0]  count, count_nxt;
  logic           wrap;
  logic [XW-1:0]  start_x;
  logic [CW-1:0]  start_c;
  logic [REQ_W-1:0]   pw_cl;
  logic [WIDTH_W-1:0] pw_k;
  logic [EW-1:0]      end_val;

  ips_cmd_t           cmd [CHANNELS];
  logic [CHANNELS-1:0] pin_nxt, act_nxt;
  logic [WIDTH_W-1:0] width_nxt [CHANNELS];
  logic [CW-1:0]      sched_nxt [CHANNELS];

  logic [PW-1:0] pins_x;
  logic [XW-1:0] sched_x, count_x;
  ips_out_t      result;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || out_free;
  assign fire      = s1_valid_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  ips_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  assign is_tick  = s1_data_r.opcode == OP_TICK;
  assign ch_ok    = 32'(s1_data_r.channel) < CHANNELS;
  assign chan_idx = ch_ok ? s1_data_r.channel[CIW-1:0] : '0;
  assign rej      = !is_tick && (!cfg.enabled || !ch_ok);

  assign start_x = XW'(s1_data_r.start_time);
  assign start_c = start_x[CW-1:0];

  always_comb begin
    priority if (s1_data_r.pulse_width < REQ_W'(cfg.min_w)) begin
      pw_cl = REQ_W'(cfg.min_w);
    end else if (s1_data_r.pulse_width > REQ_W'(cfg.max_w)) begin
      pw_cl = REQ_W'(cfg.max_w);
    end else begin
      pw_cl = s1_data_r.pulse_width;
    end
  end

  assign pw_k     = pw_cl[WIDTH_W-1:0];
  assign over     = pw_cl > REQ_W'(cfg.safety);
  assign passed   = start_c <= count;
  assign end_val  = EW'(start_c) + EW'(pw_k);
  assign do_sched = !is_tick && !rej && (s1_data_r.opcode == OP_SCHED);
  assign do_load  = do_sched && !over && !passed;
  assign do_halt  = (!is_tick && !rej && (s1_data_r.opcode == OP_STOP))
                    || (do_sched && over);

  ips_timebase #(
    .CW (CW)
  ) u_timebase (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (fire && is_tick),
    .period    (cfg.period),
    .count     (count),
    .count_nxt (count_nxt),
    .wrap      (wrap)
  );

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    always_comb begin
      cmd[i].tick = fire && is_tick;
      cmd[i].load = fire && do_load && (chan_idx == CIW'(i));
      cmd[i].halt = fire && do_halt && (chan_idx == CIW'(i));
    end

    ips_channel #(
      .CW (CW),
      .EW (EW)
    ) u_channel (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd[i]),
      .wrap       (wrap),
      .count      (count),
      .count_nxt  (count_nxt),
      .load_start (start_c),
      .load_end   (end_val),
      .load_width (pw_k),
      .pin_nxt    (pin_nxt[i]),
      .active_nxt (act_nxt[i]),
      .width_nxt  (width_nxt[i]),
      .sched_nxt  (sched_nxt[i])
    );
  end

  assign pins_x  = PW'(pin_nxt);
  assign sched_x = XW'(sched_nxt[chan_idx]);
  assign count_x = XW'(count_nxt);

  always_comb begin
    result.ok         = 1'b0;
    result.error_code = ERR_NONE;
    priority if (is_tick) begin
      result.ok = 1'b1;
    end else if (rej) begin
      result.error_code = ERR_REJECTED;
    end else if (do_sched && over) begin
      result.error_code = ERR_SAFETY;
    end else if (do_sched && passed) begin
      result.error_code = ERR_PASSED;
    end else begin
      result.ok = 1'b1;
    end
    result.pin_levels         = pins_x[PINS_W-1:0];
    result.channel_active     = ch_ok && act_nxt[chan_idx];
    result.channel_width      = ch_ok ? width_nxt[chan_idx] : '0;
    result.channel_last_count = ch_ok ? sched_x[TIME_W-1:0] : '0;
    result.current_count      = count_x[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### sv/ips_checker.sv
// Port-level checks of the injector pulse scheduler and their binding.
`default_nettype none
module ips_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         out_valid,
  input  wire logic         out_ready,
  input  ips_pkg::ips_out_t out_data
);
  import ips_pkg::*;

  a_ok_matches_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.ok == (out_data.error_code == ERR_NONE)))
    else $error("Result word ok flag disagrees with its error code.");

  a_idle_channel_no_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.channel_active) |-> (out_data.channel_width == '0))
    else $error("Inactive channel reports a nonzero width.");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("Result word dropped before it was taken.");

  a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_data))
    else $error("Result word changed while stalled.");

endmodule

bind injector_pulse_scheduler_top ips_checker u_ips_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the injector pulse scheduler top level.
`timescale 1ns / 100ps
module tb;
  import ips_pkg::*;

  localparam int NCH = CHANNELS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ips_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ips_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  injector_pulse_scheduler_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Register settings and channel state as the block should hold them.
  logic               set_en;
  logic [WIDTH_W-1:0] set_min_w;
  logic [WIDTH_W-1:0] set_max_w;
  logic [WIDTH_W-1:0] set_safety;
  logic [TIME_W-1:0]  set_period;
  logic [TIME_W-1:0]  tb_time;
  logic [TIME_W-1:0]  start_at[NCH];
  logic [TIME_W:0]    stop_at[NCH];
  logic               held_low[NCH];
  logic               pin_hi[NCH];
  logic               armed[NCH];
  logic [WIDTH_W-1:0] width_kept[NCH];
  logic [TIME_W-1:0]  booked_at[NCH];

  ips_in_t  pending_words[$];
  ips_out_t expected_results[$];
  logic [TIME_W-1:0] gen_count = '0;
  logic idle_on = 1'b0;
  int hold_asked = 0;
  int hold_seen = 0;
  int in_gap = 0;
  int out_stall = 0;
  int mismatches = 0;
  int results_seen = 0;
  int cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void reset_state();
    set_en = 1'b0;
    set_min_w = MIN_W_RST;
    set_max_w = MAX_W_RST;
    set_safety = SAFETY_RST;
    set_period = PERIOD_RST;
    tb_time = '0;
    for (int c = 0; c < NCH; c++) begin
      start_at[c] = '0;
      stop_at[c] = '0;
      held_low[c] = 1'b1;
      pin_hi[c] = 1'b0;
      armed[c] = 1'b0;
      width_kept[c] = '0;
      booked_at[c] = '0;
    end
  endfunction

  function automatic void cut_channel(int c);
    held_low[c] = 1'b1;
    pin_hi[c] = 1'b0;
    width_kept[c] = '0;
    armed[c] = 1'b0;
  endfunction

  function automatic void step_time_base();
    logic [TIME_W:0] nxt;
    logic wrapped;
    nxt = {1'b0, tb_time} + (TIME_W+1)'(1);
    wrapped = 1'b0;
    if (nxt >= {1'b0, set_period}) begin
      nxt = '0;
      wrapped = 1'b1;
    end
    tb_time = nxt[TIME_W-1:0];
    for (int c = 0; c < NCH; c++) begin
      if (wrapped) pin_hi[c] = 1'b0;
      if (held_low[c]) begin
        pin_hi[c] = 1'b0;
      end else begin
        if (tb_time == start_at[c]) pin_hi[c] = 1'b1;
        if ({1'b0, tb_time} == stop_at[c]) pin_hi[c] = 1'b0;
      end
    end
  endfunction

  function automatic ips_out_t resolve_word(ips_in_t w);
    ips_out_t r;
    logic known;
    int c;
    logic [REQ_W-1:0] pw;
    r = '0;
    known = (int'(w.channel) < NCH);
    c = known ? int'(w.channel) : 0;
    if (w.opcode == OP_TICK) begin
      step_time_base();
      r.ok = 1'b1;
    end else if (!set_en || !known) begin
      r.error_code = ERR_REJECTED;
    end else if (w.opcode == OP_SCHED) begin
      pw = w.pulse_width;
      if (pw < REQ_W'(set_min_w)) pw = REQ_W'(set_min_w);
      else if (pw > REQ_W'(set_max_w)) pw = REQ_W'(set_max_w);
      if (pw > REQ_W'(set_safety)) begin
        cut_channel(c);
        r.error_code = ERR_SAFETY;
      end else if (w.start_time <= tb_time) begin
        r.error_code = ERR_PASSED;
      end else begin
        start_at[c] = w.start_time;
        stop_at[c] = {1'b0, w.start_time} + (TIME_W+1)'(pw);
        held_low[c] = 1'b0;
        width_kept[c] = pw[WIDTH_W-1:0];
        armed[c] = 1'b1;
        booked_at[c] = tb_time;
        r.ok = 1'b1;
      end
    end else if (w.opcode == OP_STOP) begin
      cut_channel(c);
      r.ok = 1'b1;
    end else begin
      r.ok = 1'b1;
    end
    for (int k = 0; k < NCH; k++) r.pin_levels[k] = pin_hi[k];
    if (known) begin
      r.channel_active = armed[c];
      r.channel_width = width_kept[c];
      r.channel_last_count = booked_at[c];
    end
    r.current_count = tb_time;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Sender: presents queued words and predicts each one as it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(resolve_word(in_data));
      if (in_valid && !in_ready) begin
      end else if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
        in_gap <= int'($urandom_range(0, 9));
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_data <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result word and paces out_ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          ips_out_t want;
          want = expected_results.pop_front();
          check_field("ok", 32'(out_data.ok), 32'(want.ok));
          check_field("error_code", 32'(out_data.error_code), 32'(want.error_code));
          check_field("pin_levels", 32'(out_data.pin_levels), 32'(want.pin_levels));
          check_field("channel_active", 32'(out_data.channel_active),
                      32'(want.channel_active));
          check_field("channel_width", 32'(out_data.channel_width),
                      32'(want.channel_width));
          check_field("channel_last_count", 32'(out_data.channel_last_count),
                      32'(want.channel_last_count));
          check_field("current_count", 32'(out_data.current_count),
                      32'(want.current_count));
        end
        results_seen++;
      end
      if (hold_seen != hold_asked) begin
        hold_seen <= hold_asked;
        out_stall <= 80;
        out_ready <= 1'b0;
      end else if (out_stall != 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= int'($urandom_range(0, 9));
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic ips_in_t word(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
                                   logic [TIME_W-1:0] start, logic [REQ_W-1:0] pw);
    ips_in_t w;
    w.opcode = op;
    w.channel = ch;
    w.start_time = start;
    w.pulse_width = pw;
    return w;
  endfunction

  task automatic queue_word(ips_in_t w);
    logic [TIME_W:0] nxt;
    pending_words.push_back(w);
    if (w.opcode == OP_TICK) begin
      nxt = {1'b0, gen_count} + (TIME_W+1)'(1);
      if (nxt >= {1'b0, set_period}) nxt = '0;
      gen_count = nxt[TIME_W-1:0];
    end
  endtask

  task automatic queue_random_words(int n);
    int r;
    int span;
    int reach;
    logic [CH_W-1:0] ch;
    logic [REQ_W-1:0] pw;
    for (int i = 0; i < n; i++) begin
      r = int'($urandom_range(0, 99));
      ch = ($urandom_range(0, 9) == 0) ? CH_W'($urandom_range(4, 15))
                                        : CH_W'($urandom_range(0, NCH - 1));
      span = (set_min_w > set_max_w) ? int'(set_min_w) : int'(set_max_w);
      span = span + span / 4 + 4;
      if (span > 24'hFFFFFF) span = 24'hFFFFFF;
      pw = REQ_W'($urandom_range(0, span));
      reach = (set_period > 40) ? 40 : int'(set_period);
      if (r < 55) begin
        queue_word(word(OP_TICK, ch, TIME_W'($urandom), REQ_W'($urandom)));
      end else if (r < 75) begin
        queue_word(word(OP_SCHED, ch, TIME_W'(gen_count + $urandom_range(1, reach)), pw));
      end else if (r < 80) begin
        queue_word(word(OP_SCHED, ch, TIME_W'(gen_count - $urandom_range(0, 5)), pw));
      end else if (r < 85) begin
        queue_word(word(OP_SCHED, ch, TIME_W'($urandom), REQ_W'($urandom)));
      end else if (r < 93) begin
        queue_word(word(OP_STOP, ch, TIME_W'($urandom), REQ_W'($urandom)));
      end else begin
        queue_word(word(OP_STATUS, ch, TIME_W'($urandom), REQ_W'($urandom)));
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ENABLE: set_en = val[0];
      CFG_MIN_W:  set_min_w = val[WIDTH_W-1:0];
      CFG_MAX_W:  set_max_w = val[WIDTH_W-1:0];
      CFG_SAFETY: set_safety = val[WIDTH_W-1:0];
      CFG_PERIOD: set_period = val[TIME_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic en, int min_w, int max_w, int safety, int period);
    write_reg(CFG_PERIOD, CFG_DATA_W'(period));
    write_reg(CFG_MIN_W, CFG_DATA_W'(min_w));
    write_reg(CFG_MAX_W, CFG_DATA_W'(max_w));
    write_reg(CFG_SAFETY, CFG_DATA_W'(safety));
    write_reg(CFG_ENABLE, CFG_DATA_W'(en));
  endtask

  initial begin
    reset_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Disabled after reset: only ticks are carried out.
    queue_word(word(OP_STATUS, CH_W'(0), '0, '0));
    queue_word(word(OP_TICK, CH_W'(0), '0, '0));
    queue_word(word(OP_SCHED, CH_W'(1), 25'd100, 24'd600));
    queue_word(word(OP_STOP, CH_W'(2), '0, '0));
    queue_word(word(OP_TICK, CH_W'(15), 25'h1FFFFFF, 24'hFFFFFF));
    wait_drained();

    set_all(1'b1, 3, 20, 15, 10);
    queue_word(word(OP_SCHED, CH_W'(0), TIME_W'(gen_count + 2), 24'd5));
    queue_word(word(OP_SCHED, CH_W'(1), TIME_W'(gen_count + 3), 24'd0));
    queue_word(word(OP_SCHED, CH_W'(2), TIME_W'(gen_count + 1), 24'hFFFFFF));
    queue_word(word(OP_SCHED, CH_W'(3), gen_count, 24'd6));
    queue_word(word(OP_SCHED, CH_W'(4), TIME_W'(gen_count + 1), 24'd6));
    queue_word(word(OP_SCHED, CH_W'(15), TIME_W'(gen_count + 1), 24'd6));
    queue_word(word(OP_SCHED, CH_W'(3), 25'h1FFFFFF, 24'd15));
    queue_word(word(OP_SCHED, CH_W'(3), TIME_W'(gen_count + 6), 24'd10));
    for (int i = 0; i < 12; i++) queue_word(word(OP_TICK, CH_W'(i % 5), '0, '0));
    queue_word(word(OP_STOP, CH_W'(0), '0, '0));
    queue_word(word(OP_STATUS, CH_W'(1), '0, '0));
    queue_word(word(OP_STATUS, CH_W'(15), '0, '0));
    wait_drained();

    idle_on = 1'b1;
    set_all(1'b1, 3, 20, 15, 50);
    queue_random_words(120);
    hold_asked++;
    queue_random_words(130);
    wait_drained();

    idle_on = 1'b0;
    set_all(1'b1, 30, 10, 40, 100);
    queue_random_words(200);
    wait_drained();

    idle_on = 1'b1;
    set_all(1'b1, 0, 20'hFFFFF, 20'hFFFFF, 25'h1FFFFFF);
    queue_random_words(150);
    wait_drained();

    set_all(1'b1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 2);
    queue_random_words(100);
    wait_drained();

    set_all(1'b1, 0, 8, 0, 7);
    queue_random_words(100);
    wait_drained();

    set_all(1'b0, 2, 12, 12, 40);
    queue_random_words(100);
    wait_drained();

    idle_on = 1'b0;
    set_all(1'b1, 2, 12, 12, 40);
    queue_random_words(150);
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
